FILE: design/troi_pkg.sv
// Shared types, constants and helpers for the truncated octahedron re-imager.
`default_nettype none

package troi_pkg;

    // Member run limit and the counter width that follows from it
    localparam int MAX_MEMBERS = 255;
    localparam int MEMBER_W    = $clog2(MAX_MEMBERS + 1);

    // Queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Axes
    localparam int NAXES = 3;
    localparam int AX_X  = 0;
    localparam int AX_Y  = 1;
    localparam int AX_Z  = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_Z       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD_Z = 3'd7;

    // Reset values of the box registers
    localparam logic [30:0] WALL_RESET = 31'd65536;
    localparam logic [31:0] INV_RESET  = 32'd8388608;

    // Q.40 fixed-point constants: one, one half and the 0.75 corner limit
    localparam logic [40:0] ONE_Q40   = 41'd1 << 40;
    localparam logic [39:0] HALF_Q40  = 40'd1 << 39;
    localparam logic [41:0] LIMIT_Q40 = 42'd3 << 38;
    localparam logic [53:0] ROUND_Q20 = 54'd1 << 19;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
    } front_cfg_t;

    typedef struct packed {
        logic [NAXES-1:0][30:0] wall;
        logic [NAXES-1:0][31:0] inv;
    } back_cfg_t;

    // One classified atom waiting for the back end
    typedef struct packed {
        logic signed [32:0]  dx;
        logic signed [32:0]  dy;
        logic signed [31:0]  dz;
        logic                major;
        logic [MEMBER_W-1:0] count;
    } q_entry_t;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_MUL1 = 5'b00010,
        S_FOLD = 5'b00100,
        S_MUL2 = 5'b01000,
        S_DONE = 5'b10000
    } back_state_t;

    // Clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/troi_front.sv
// Front end: accepts atoms, removes the reference offset and clamps the member count.
`default_nettype none

module troi_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire troi_pkg::front_cfg_t cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic                 is_major,
    input  wire logic [7:0]           member_count,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output troi_pkg::q_entry_t        push_data
);

    logic               ent_valid_reg;
    logic               ent_valid_next;
    troi_pkg::q_entry_t ent_reg;
    troi_pkg::q_entry_t ent_next;
    logic               in_fire;

    // Take a new transaction whenever the holding stage is empty or draining
    assign in_ready   = !ent_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = ent_valid_reg;
    assign push_data  = ent_reg;

    // Classify: subtract offsets exactly, clamp the run length
    always_comb
    begin
        ent_next.dx    = 33'(pos_x) - 33'(cfg.offset_x);
        ent_next.dy    = 33'(pos_y) - 33'(cfg.offset_y);
        ent_next.dz    = pos_z;
        ent_next.major = is_major;
        if (32'(member_count) > troi_pkg::MAX_MEMBERS)
            ent_next.count = troi_pkg::MEMBER_W'(troi_pkg::MAX_MEMBERS);
        else
            ent_next.count = troi_pkg::MEMBER_W'(member_count);
    end

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (in_fire)
            ent_valid_next = 1'b1;
        else if (push_ready)
            ent_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_valid_reg <= 1'b0;
        else
            ent_valid_reg <= ent_valid_next;
    end

    // Hold payload until the queue takes it
    always_ff @(posedge clk)
    begin
        if (in_fire)
            ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

FILE: design/troi_queue.sv
// Short queue that decouples the front end from the back end.
`default_nettype none

module troi_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire troi_pkg::q_entry_t push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output troi_pkg::q_entry_t      pop_data
);

    troi_pkg::q_entry_t                entry_reg [troi_pkg::QDEPTH];
    logic [troi_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [troi_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [troi_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [troi_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [troi_pkg::QCNT_W-1:0]       count_reg;
    logic [troi_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = count_reg != troi_pkg::QCNT_W'(troi_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == troi_pkg::QPTR_W'(troi_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == troi_pkg::QPTR_W'(troi_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an entry on push
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

FILE: design/troi_back.sv
// Back end: applies member shifts, wraps heads into the box and drives results.
`default_nettype none

module troi_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire troi_pkg::back_cfg_t cfg,
    input  wire logic                q_valid,
    output logic                     q_pop,
    input  wire troi_pkg::q_entry_t  q_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       out_x,
    output logic signed [31:0]       out_y,
    output logic signed [31:0]       out_z
);

    localparam int N = troi_pkg::NAXES;

    troi_pkg::back_state_t state_reg;
    troi_pkg::back_state_t state_next;

    // Control state
    logic [troi_pkg::MEMBER_W-1:0] members_left_reg;
    logic [troi_pkg::MEMBER_W-1:0] members_left_next;
    logic signed [31:0]            shift_x_reg;
    logic signed [31:0]            shift_x_next;
    logic signed [31:0]            shift_y_reg;
    logic signed [31:0]            shift_y_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    // Datapath registers
    logic signed [31:0]            d_reg     [N];
    logic signed [31:0]            d_next    [N];
    logic                          major_reg;
    logic [troi_pkg::MEMBER_W-1:0] count_reg;
    logic [39:0]                   prod_reg  [N];
    logic [39:0]                   prod_next [N];
    logic [39:0]                   gmag_reg  [N];
    logic [39:0]                   gmag_next [N];
    logic [N-1:0]                  gneg_reg;
    logic [N-1:0]                  gneg_next;
    logic [51:0]                   pa_reg    [N];
    logic [51:0]                   pa_next   [N];
    logic [51:0]                   pb_reg    [N];
    logic [51:0]                   pb_next   [N];
    logic signed [31:0]            o_reg     [N];
    logic signed [31:0]            o_next    [N];

    // Combinational helpers
    logic signed [34:0]            sum_x;
    logic signed [34:0]            sum_y;
    logic [31:0]                   dmag      [N];
    logic [63:0]                   full      [N];
    logic [39:0]                   fmag      [N];
    logic [N-1:0]                  fneg;
    logic [N-1:0]                  gneg0;
    logic [41:0]                   gsum;
    logic                          over;
    logic [31:0]                   period    [N];
    logic [53:0]                   rsum      [N];
    logic signed [34:0]            rval      [N];
    logic signed [34:0]            dif_x;
    logic signed [34:0]            dif_y;
    logic                          shift_add;
    logic                          out_fire;

    assign out_valid = out_valid_reg;
    assign out_x     = o_reg[troi_pkg::AX_X];
    assign out_y     = o_reg[troi_pkg::AX_Y];
    assign out_z     = o_reg[troi_pkg::AX_Z];
    assign out_fire  = (state_reg == troi_pkg::S_DONE) && (!out_valid_reg || out_ready);

    // Add the pending head shift and saturate
    always_comb
    begin
        shift_add = members_left_reg != '0;
        sum_x = 35'(q_data.dx) + (shift_add ? 35'(shift_x_reg) : 35'sd0);
        sum_y = 35'(q_data.dy) + (shift_add ? 35'(shift_y_reg) : 35'sd0);
        d_next[troi_pkg::AX_X] = troi_pkg::sat32(sum_x);
        d_next[troi_pkg::AX_Y] = troi_pkg::sat32(sum_y);
        d_next[troi_pkg::AX_Z] = q_data.dz;
    end

    // Per-axis arithmetic: normalize, fold, corner cut, rescale
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            dmag[i]      = d_reg[i][31] ? (~d_reg[i] + 32'd1) : d_reg[i];
            full[i]      = 64'(dmag[i]) * 64'(cfg.inv[i]);
            prod_next[i] = full[i][39:0];

            if (prod_reg[i][39])
            begin
                fmag[i] = 40'(troi_pkg::ONE_Q40 - 41'(prod_reg[i]));
                fneg[i] = !d_reg[i][31];
            end
            else
            begin
                fmag[i] = prod_reg[i];
                fneg[i] = d_reg[i][31];
            end
            gneg0[i] = fneg[i] && (fmag[i] != '0);
        end

        gsum = 42'(fmag[0]) + 42'(fmag[1]) + 42'(fmag[2]);
        over = gsum > troi_pkg::LIMIT_Q40;

        for (int i = 0; i < N; i++)
        begin
            if (over)
            begin
                gmag_next[i] = troi_pkg::HALF_Q40 - fmag[i];
                gneg_next[i] = !gneg0[i] && (fmag[i] != troi_pkg::HALF_Q40);
            end
            else
            begin
                gmag_next[i] = fmag[i];
                gneg_next[i] = gneg0[i];
            end

            period[i]  = {cfg.wall[i], 1'b0};
            pa_next[i] = 52'(gmag_reg[i][39:20]) * 52'(period[i]);
            pb_next[i] = 52'(gmag_reg[i][19:0]) * 52'(period[i]);

            rsum[i] = 54'(pa_reg[i]) + troi_pkg::ROUND_Q20 + 54'(pb_reg[i] >> 20);
            rval[i] = $signed({1'b0, rsum[i][53:20]});
            if (major_reg)
                o_next[i] = troi_pkg::sat32(gneg_reg[i] ? -rval[i] : rval[i]);
            else
                o_next[i] = d_reg[i];
        end

        dif_x = 35'(o_next[troi_pkg::AX_X]) - 35'(d_reg[troi_pkg::AX_X]);
        dif_y = 35'(o_next[troi_pkg::AX_Y]) - 35'(d_reg[troi_pkg::AX_Y]);
    end

    // Sequence one head atom through load, multiply, fold, multiply, finish
    always_comb
    begin
        state_next        = state_reg;
        q_pop             = 1'b0;
        members_left_next = members_left_reg;
        shift_x_next      = shift_x_reg;
        shift_y_next      = shift_y_reg;
        out_valid_next    = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            troi_pkg::S_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (shift_add)
                        members_left_next = members_left_reg - 1'b1;
                    state_next = q_data.major ? troi_pkg::S_MUL1 : troi_pkg::S_DONE;
                end
            end
            troi_pkg::S_MUL1: state_next = troi_pkg::S_FOLD;
            troi_pkg::S_FOLD: state_next = troi_pkg::S_MUL2;
            troi_pkg::S_MUL2: state_next = troi_pkg::S_DONE;
            troi_pkg::S_DONE:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b1;
                    if (major_reg && (count_reg != '0))
                    begin
                        shift_x_next      = troi_pkg::sat32(dif_x);
                        shift_y_next      = troi_pkg::sat32(dif_y);
                        members_left_next = count_reg;
                    end
                    state_next = troi_pkg::S_LOAD;
                end
            end
            default: state_next = troi_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= troi_pkg::S_LOAD;
            members_left_reg <= '0;
            shift_x_reg      <= '0;
            shift_y_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            members_left_reg <= members_left_next;
            shift_x_reg      <= shift_x_next;
            shift_y_reg      <= shift_y_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Load datapath registers in their own step
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            d_reg     <= d_next;
            major_reg <= q_data.major;
            count_reg <= q_data.count;
        end
        if (state_reg == troi_pkg::S_MUL1)
            prod_reg <= prod_next;
        if (state_reg == troi_pkg::S_FOLD)
        begin
            gmag_reg <= gmag_next;
            gneg_reg <= gneg_next;
        end
        if (state_reg == troi_pkg::S_MUL2)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (out_fire)
            o_reg <= o_next;
    end

    // A result only appears out of the finishing step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == troi_pkg::S_DONE))
        else $error("result raised outside the finishing step");

    // A pending run shrinks by exactly one per member taken
    a_member_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == troi_pkg::S_LOAD && q_valid && members_left_reg != '0) |=>
        (members_left_reg == troi_pkg::MEMBER_W'($past(members_left_reg) - 1'b1)))
        else $error("member run count did not step down");

    // Folded fractions stay within one half
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == troi_pkg::S_MUL2) |->
        (gmag_reg[0] <= troi_pkg::HALF_Q40 && gmag_reg[1] <= troi_pkg::HALF_Q40 &&
         gmag_reg[2] <= troi_pkg::HALF_Q40))
        else $error("folded fraction above one half");

    // A plain atom skips the multiply path; it may wait in the finishing step
    a_plain_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == troi_pkg::S_DONE && !major_reg) |->
        ($past(state_reg == troi_pkg::S_LOAD) || $past(state_reg == troi_pkg::S_DONE)))
        else $error("plain atom went through the wrap path");

endmodule

`default_nettype wire

FILE: design/truncated_octahedron_reimage_core.sv
// Top level of the truncated octahedron re-imager: configuration registers and wiring.
//
//   channel   direction  transaction
//   in        sink       in_valid/in_ready: pos_x, pos_y, pos_z, is_major, member_count
//   out       source     out_valid/out_ready: out_x, out_y, out_z
//   cfg       sink       cfg_we: cfg_index, cfg_data (write only, no wait)
//
// In the back end a head atom goes through load, normalize multiply, fold, rescale
// multiply and finish; others go from load to finish. The sequencer sets the rate.
// The front end and a 2-entry queue keep accepting while the back end works or
// while a result waits in the output register. Reset clears the member run and
// the shift; the box registers return to a unit wall and half inverse period.
`default_nettype none

module truncated_octahedron_reimage_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [troi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [31:0]                pos_x,
    input  wire logic signed [31:0]                pos_y,
    input  wire logic signed [31:0]                pos_z,
    input  wire logic                              is_major,
    input  wire logic [7:0]                        member_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [31:0]                     out_x,
    output logic signed [31:0]                     out_y,
    output logic signed [31:0]                     out_z
);

    troi_pkg::front_cfg_t front_cfg_reg;
    troi_pkg::front_cfg_t front_cfg_next;
    troi_pkg::back_cfg_t  back_cfg_reg;
    troi_pkg::back_cfg_t  back_cfg_next;

    logic                 push_valid;
    logic                 push_ready;
    troi_pkg::q_entry_t   push_data;
    logic                 q_valid;
    logic                 q_pop;
    troi_pkg::q_entry_t   q_data;

    // Decode register writes
    always_comb
    begin
        front_cfg_next = front_cfg_reg;
        back_cfg_next  = back_cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                troi_pkg::REG_OFFSET_X:     front_cfg_next.offset_x = $signed(cfg_data);
                troi_pkg::REG_OFFSET_Y:     front_cfg_next.offset_y = $signed(cfg_data);
                troi_pkg::REG_WALL_X:       back_cfg_next.wall[troi_pkg::AX_X] = cfg_data[30:0];
                troi_pkg::REG_WALL_Y:       back_cfg_next.wall[troi_pkg::AX_Y] = cfg_data[30:0];
                troi_pkg::REG_WALL_Z:       back_cfg_next.wall[troi_pkg::AX_Z] = cfg_data[30:0];
                troi_pkg::REG_INV_PERIOD_X: back_cfg_next.inv[troi_pkg::AX_X] = cfg_data;
                troi_pkg::REG_INV_PERIOD_Y: back_cfg_next.inv[troi_pkg::AX_Y] = cfg_data;
                troi_pkg::REG_INV_PERIOD_Z: back_cfg_next.inv[troi_pkg::AX_Z] = cfg_data;
                default:                    front_cfg_next = front_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.offset_x <= '0;
            front_cfg_reg.offset_y <= '0;
            for (int i = 0; i < troi_pkg::NAXES; i++)
            begin
                back_cfg_reg.wall[i] <= troi_pkg::WALL_RESET;
                back_cfg_reg.inv[i]  <= troi_pkg::INV_RESET;
            end
        end
        else
        begin
            front_cfg_reg <= front_cfg_next;
            back_cfg_reg  <= back_cfg_next;
        end
    end

    troi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (front_cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .is_major     (is_major),
        .member_count (member_count),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    troi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    troi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

endmodule

`default_nettype wire

FILE: tb/sv/truncated_octahedron_reimage_core_tb.sv
// Self-checking testbench for the truncated octahedron re-imager core.
`timescale 1ns / 100ps

module truncated_octahedron_reimage_core_tb;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     DRAIN_CYCLES   = 12;
    localparam int     MAX_REPORTS    = 10;
    localparam longint FRAC_HALF      = longint'(1) << 39;
    localparam longint CORNER_LIMIT   = longint'(3) << 38;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               major;
        logic [7:0]         count;
    } atom_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    typedef struct {
        logic signed [31:0] ofs_x;
        logic signed [31:0] ofs_y;
        logic [30:0]        wall_x;
        logic [30:0]        wall_y;
        logic [30:0]        wall_z;
        logic [31:0]        inv_x;
        logic [31:0]        inv_y;
        logic [31:0]        inv_z;
    } box_cfg_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [troi_pkg::CFG_IDX_W-1:0] cfg_index    = troi_pkg::REG_OFFSET_X;
    logic [31:0]                    cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic signed [31:0]             pos_x        = '0;
    logic signed [31:0]             pos_y        = '0;
    logic signed [31:0]             pos_z        = '0;
    logic                           is_major     = 1'b0;
    logic [7:0]                     member_count = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic signed [31:0]             out_x;
    logic signed [31:0]             out_y;
    logic signed [31:0]             out_z;

    // Mirror of the box registers and the pending member run
    box_cfg_t box;
    int       run_left;
    longint   run_shift_x;
    longint   run_shift_y;

    pos_t     expected_pos_q[$];
    pos_t     next_pos;
    int       idle_pct        = 31;
    int       quiet_cycles    = 0;
    int       errors          = 0;
    int       atoms_sent      = 0;
    int       results_checked = 0;
    int       heads_seen      = 0;
    int       members_shifted = 0;
    int       corner_folds    = 0;
    int       box_loads       = 0;

    truncated_octahedron_reimage_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .is_major     (is_major),
        .member_count (member_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic longint clamp_s32(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return longint'(32'sh7FFF_FFFF);
        if (v < longint'(32'sh8000_0000))
            return longint'(32'sh8000_0000);
        return v;
    endfunction

    // Fractional image of d * inv as signed Q.40 within one half
    function automatic longint fold_fraction(longint d, logic [31:0] inv);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [39:0] frac;
        neg  = (d < 0);
        mag  = neg ? 64'(-d) : 64'(d);
        prod = mag * {32'd0, inv};
        frac = prod[39:0];
        // at or past one half: take the image from the other side
        if (frac[39])
        begin
            frac = ~frac + 40'd1;
            neg  = !neg;
        end
        return neg ? -longint'({24'd0, frac}) : longint'({24'd0, frac});
    endfunction

    // Scale a Q.40 fraction by the period, round half away from zero to Q16.16
    function automatic longint scale_to_box(longint g, logic [30:0] wall);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] per;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] q;
        neg = (g < 0);
        mag = neg ? 64'(-g) : 64'(g);
        per = {32'd0, wall, 1'b0};
        hi  = (mag >> 20) * per;
        lo  = (mag & 64'hF_FFFF) * per;
        q   = (hi + 64'd524288 + (lo >> 20)) >> 20;
        return clamp_s32(neg ? -longint'(q) : longint'(q));
    endfunction

    function automatic pos_t reimage_atom(atom_t a);
        longint dx;
        longint dy;
        longint dz;
        longint gx;
        longint gy;
        longint gz;
        longint ox;
        longint oy;
        longint oz;
        pos_t   r;
        dx = longint'(a.x) - longint'(box.ofs_x);
        dy = longint'(a.y) - longint'(box.ofs_y);
        dz = longint'(a.z);
        // apply the shift of the head that owns this atom
        if (run_left != 0)
        begin
            dx += run_shift_x;
            dy += run_shift_y;
            run_left--;
            members_shifted++;
        end
        dx = clamp_s32(dx);
        dy = clamp_s32(dy);
        ox = dx;
        oy = dy;
        oz = dz;
        if (a.major)
        begin
            heads_seen++;
            gx = fold_fraction(dx, box.inv_x);
            gy = fold_fraction(dy, box.inv_y);
            gz = fold_fraction(dz, box.inv_z);
            // outside the hexagonal faces: move by half a period on every axis
            if ((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy) + (gz < 0 ? -gz : gz)
                    > CORNER_LIMIT)
            begin
                gx = (gx < 0) ? gx + FRAC_HALF : gx - FRAC_HALF;
                gy = (gy < 0) ? gy + FRAC_HALF : gy - FRAC_HALF;
                gz = (gz < 0) ? gz + FRAC_HALF : gz - FRAC_HALF;
                corner_folds++;
            end
            ox = scale_to_box(gx, box.wall_x);
            oy = scale_to_box(gy, box.wall_y);
            oz = scale_to_box(gz, box.wall_z);
            // a head with members starts a new run, replacing any pending one
            if (a.count != 0)
            begin
                run_shift_x = clamp_s32(ox - dx);
                run_shift_y = clamp_s32(oy - dy);
                run_left    = (a.count > troi_pkg::MAX_MEMBERS) ?
                              troi_pkg::MAX_MEMBERS : int'(a.count);
            end
        end
        r.x = 32'(ox);
        r.y = 32'(oy);
        r.z = 32'(oz);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic atom_t mk_atom(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z, logic major,
                                      logic [7:0] count);
        atom_t a;
        a.x     = x;
        a.y     = y;
        a.z     = z;
        a.major = major;
        a.count = count;
        return a;
    endfunction

    function automatic atom_t rand_atom();
        atom_t a;
        a.x     = $urandom();
        a.y     = $urandom();
        a.z     = $urandom();
        a.major = 1'($urandom_range(0, 1));
        a.count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
        return a;
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic logic [31:0] inv_for_wall(logic [30:0] wall);
        logic [63:0] q;
        q = (64'd1 << 39) / {33'd0, wall};
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // A box of realistic size with matching inverse periods
    function automatic box_cfg_t random_box();
        box_cfg_t c;
        c.wall_x = 31'($urandom_range(1 << 12, 1 << 22));
        if ($urandom_range(0, 1) == 0)
        begin
            c.wall_y = c.wall_x;
            c.wall_z = c.wall_x;
        end
        else
        begin
            c.wall_y = 31'($urandom_range(1 << 12, 1 << 22));
            c.wall_z = 31'($urandom_range(1 << 12, 1 << 22));
        end
        c.inv_x = inv_for_wall(c.wall_x);
        c.inv_y = inv_for_wall(c.wall_y);
        c.inv_z = inv_for_wall(c.wall_z);
        c.ofs_x = 32'(jitter(1 << 24));
        c.ofs_y = 32'(jitter(1 << 24));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    task automatic put_reg(input logic [troi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write every box register; call only with the block idle
    task automatic load_box(input box_cfg_t c);
        put_reg(troi_pkg::REG_OFFSET_X, c.ofs_x);
        put_reg(troi_pkg::REG_OFFSET_Y, c.ofs_y);
        put_reg(troi_pkg::REG_WALL_X, {1'b0, c.wall_x});
        put_reg(troi_pkg::REG_WALL_Y, {1'b0, c.wall_y});
        put_reg(troi_pkg::REG_WALL_Z, {1'b0, c.wall_z});
        put_reg(troi_pkg::REG_INV_PERIOD_X, c.inv_x);
        put_reg(troi_pkg::REG_INV_PERIOD_Y, c.inv_y);
        put_reg(troi_pkg::REG_INV_PERIOD_Z, c.inv_z);
        cfg_we <= 1'b0;
        box = c;
        box_loads++;
        @(posedge clk);
    endtask

    task automatic send_atom(input atom_t a);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pos_x        <= a.x;
        pos_y        <= a.y;
        pos_z        <= a.z;
        is_major     <= a.major;
        member_count <= a.count;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_pos_q.push_back(reimage_atom(a));
        atoms_sent++;
    endtask

    // Hold the sender until every expected result is out, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pos_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed atoms against the reset box (unit wall, half inverse period)
    task automatic test_reset_box();
        send_atom(mk_atom(0, 0, 0, 1'b0, 8'd0));
        send_atom(mk_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 8'd0));
        // count is ignored on a non-head
        send_atom(mk_atom(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 8'd255));
        send_atom(mk_atom(0, 0, 0, 1'b1, 8'd0));
        // exactly half a period on x and y
        send_atom(mk_atom(65536, -65536, 0, 1'b1, 8'd0));
        send_atom(mk_atom(81920, 19661, -13107, 1'b1, 8'd0));
        // near a corner: the half-period fold applies
        send_atom(mk_atom(58982, 58982, 58982, 1'b1, 8'd0));
        send_atom(mk_atom(-58982, 58982, -58982, 1'b1, 8'd0));
        // extreme head whose members saturate on the shift
        send_atom(mk_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 8'd2));
        send_atom(mk_atom(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 12345, 1'b0, 8'd0));
        send_atom(mk_atom(32'sh8000_0000, 32'sh8000_0000, -1, 1'b0, 8'd0));
        // head with four members, a memberless head inside the run
        send_atom(mk_atom(373555, -209715, 72090, 1'b1, 8'd4));
        send_atom(mk_atom(380000, -200000, 70000, 1'b0, 8'd0));
        send_atom(mk_atom(370000, -215000, 75000, 1'b1, 8'd0));
        send_atom(mk_atom(360000, -190000, 80000, 1'b0, 8'd0));
        // nested head replaces the pending run
        send_atom(mk_atom(-500000, 300000, 10, 1'b1, 8'd2));
        send_atom(mk_atom(-510000, 310000, 20, 1'b0, 8'd7));
        send_atom(mk_atom(-490000, 290000, 30, 1'b0, 8'd0));
        send_atom(mk_atom(1, -1, 1, 1'b0, 8'd0));
        // full-length run left pending into the next test
        send_atom(mk_atom(-1, -1, -1, 1'b1, 8'd255));
        drain_results();
    endtask

    // Register extremes: largest walls and offsets, zero walls, mixed
    task automatic test_extreme_box();
        box_cfg_t c;
        c.ofs_x  = 32'sh7FFF_FFFF;
        c.ofs_y  = 32'sh8000_0000;
        c.wall_x = 31'h7FFF_FFFF;
        c.wall_y = 31'h7FFF_FFFF;
        c.wall_z = 31'h7FFF_FFFF;
        c.inv_x  = 32'hFFFF_FFFF;
        c.inv_y  = 32'hFFFF_FFFF;
        c.inv_z  = 32'hFFFF_FFFF;
        for (int pass = 0; pass < 3; pass++)
        begin
            if (pass == 1)
            begin
                // zero wall and zero inverse period
                c.ofs_x  = 32'sh8000_0000;
                c.ofs_y  = 32'sh7FFF_FFFF;
                c.wall_x = '0;
                c.wall_y = '0;
                c.wall_z = '0;
                c.inv_x  = '0;
                c.inv_y  = '0;
                c.inv_z  = '0;
            end
            else if (pass == 2)
            begin
                c.ofs_x  = '0;
                c.ofs_y  = '0;
                c.wall_x = 31'd1;
                c.wall_y = 31'h7FFF_FFFF;
                c.wall_z = 31'h7FFF_FFFF;
                c.inv_x  = 32'hFFFF_FFFF;
                c.inv_y  = 32'd1;
                c.inv_z  = '0;
            end
            load_box(c);
            for (int i = 0; i < 60; i++)
                send_atom(rand_atom());
            drain_results();
        end
    endtask

    // Molecules: a head followed by its members, with broken runs and noise
    task automatic test_molecule_stream();
        box_cfg_t c;
        atom_t    a;
        int       k;
        int       n;
        longint   hx;
        longint   hy;
        longint   hz;
        longint   span;
        for (int phase = 0; phase < 4; phase++)
        begin
            c = random_box();
            load_box(c);
            // one phase runs both sides without any idling
            idle_pct = (phase == 2) ? 0 : 31;
            span = longint'(c.wall_x);
            for (int mol = 0; mol < 45; mol++)
            begin
                if (mol == 30 && phase == 1)
                    k = 255;
                else if (mol == 30 && phase == 3)
                    k = $urandom_range(100, 254);
                else if ($urandom_range(0, 99) < 85)
                    k = $urandom_range(0, 6);
                else
                    k = $urandom_range(7, 30);
                n = k;
                // broken run: fewer or more members than announced
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(0, k + 3);
                hx = longint'(c.ofs_x) + jitter(6 * span);
                hy = longint'(c.ofs_y) + jitter(6 * span);
                hz = jitter(6 * span);
                send_atom(mk_atom(32'(hx), 32'(hy), 32'(hz), 1'b1, 8'(k)));
                for (int j = 0; j < n; j++)
                begin
                    a = mk_atom(32'(hx + jitter(span / 2)), 32'(hy + jitter(span / 2)),
                                32'(hz + jitter(span / 2)), 1'b0, 8'd0);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        a.major = 1'b1;
                        a.count = 8'($urandom_range(0, 4));
                    end
                    send_atom(a);
                end
                if ($urandom_range(0, 9) == 0)
                    send_atom(rand_atom());
                // hold the sender until the block has caught up
                if (mol % 20 == 19)
                    drain_results();
            end
            drain_results();
        end
        idle_pct = 31;
    endtask

    // Arbitrary register values and arbitrary atoms
    task automatic test_random_noise();
        box_cfg_t c;
        for (int round = 0; round < 3; round++)
        begin
            c.ofs_x  = $urandom();
            c.ofs_y  = $urandom();
            c.wall_x = 31'($urandom());
            c.wall_y = 31'($urandom());
            c.wall_z = 31'($urandom());
            c.inv_x  = $urandom();
            c.inv_y  = $urandom();
            c.inv_z  = $urandom();
            load_box(c);
            for (int i = 0; i < 60; i++)
                send_atom(rand_atom());
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= idle_pct);

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pos_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result x=%h y=%h z=%h", out_x, out_y, out_z);
            end
            else
            begin
                next_pos = expected_pos_q.pop_front();
                results_checked++;
                if (out_x !== next_pos.x || out_y !== next_pos.y || out_z !== next_pos.z)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result %0d: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                                 results_checked, next_pos.x, next_pos.y, next_pos.z,
                                 out_x, out_y, out_z);
                end
            end
        end
    end

    // Count cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_pos_q.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        box.ofs_x   = '0;
        box.ofs_y   = '0;
        box.wall_x  = troi_pkg::WALL_RESET;
        box.wall_y  = troi_pkg::WALL_RESET;
        box.wall_z  = troi_pkg::WALL_RESET;
        box.inv_x   = troi_pkg::INV_RESET;
        box.inv_y   = troi_pkg::INV_RESET;
        box.inv_z   = troi_pkg::INV_RESET;
        run_left    = 0;
        run_shift_x = 0;
        run_shift_y = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_box();
        test_extreme_box();
        test_molecule_stream();
        test_random_noise();
        drain_results();

        $display("sent %0d atoms (%0d heads, %0d shifted members, %0d corner folds) over %0d boxes",
                 atoms_sent, heads_seen, members_shifted, corner_folds, box_loads + 1);
        $display("checked %0d results, %0d errors", results_checked, errors);
        if (errors == 0 && expected_pos_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
